FILE: design/emt_pkg.sv
// Shared types and constants for the tick-to-microsecond elapsed timer.
package emt_pkg;

    // Field widths of the beats and of the rate register.
    localparam int TIME_BITS = 64;
    localparam int RATE_BITS = 32;
    localparam int US_BITS   = 20;
    localparam int PROD_BITS = RATE_BITS + US_BITS;
    localparam int STEP_BITS = 6;

    // Microseconds in one second, and the reset value of the rate register.
    localparam logic [US_BITS-1:0]   US_PER_SECOND = US_BITS'(1000000);
    localparam logic [RATE_BITS-1:0] RATE_RESET    = RATE_BITS'(1000000);

    // Last step of the whole-second division and of the fraction division.
    localparam logic [STEP_BITS-1:0] WHOLE_LAST = STEP_BITS'(TIME_BITS - 1);
    localparam logic [STEP_BITS-1:0] PART_LAST  = STEP_BITS'(PROD_BITS - 1);

    // Operation codes.
    localparam logic [1:0] OP_RESTART = 2'd0;
    localparam logic [1:0] OP_READ    = 2'd1;
    localparam logic [1:0] OP_CONVERT = 2'd2;
    localparam logic [1:0] OP_ARM     = 2'd3;

    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [RATE_BITS-1:0] rate_t;

    typedef struct packed {
        logic [1:0] operation;
        time_t      counter_value;
        time_t      tick_count;
        time_t      delay_us;
    } in_item_t;

    typedef struct packed {
        time_t time_us;
        logic  delay_done;
        logic  status;
    } out_item_t;

endpackage

FILE: design/emt_conv.sv
// Bit-serial tick to microsecond converter: two restoring divisions by the rate.
module emt_conv (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  emt_pkg::time_t ticks,
    input  emt_pkg::rate_t rate,
    output logic           done,
    output emt_pkg::time_t result
);
    import emt_pkg::*;

    localparam logic [2:0] C_IDLE  = 3'd0;
    localparam logic [2:0] C_WHOLE = 3'd1;
    localparam logic [2:0] C_MUL   = 3'd2;
    localparam logic [2:0] C_PART  = 3'd3;
    localparam logic [2:0] C_SUM   = 3'd4;

    logic [2:0]           state_reg, state_next;
    logic [STEP_BITS-1:0] cnt_reg, cnt_next;
    logic                 done_reg, done_next;
    time_t                dvd_reg, dvd_next;
    rate_t                rem_reg, rem_next;
    time_t                acc_reg, acc_next;
    logic [US_BITS-1:0]   part_reg, part_next;
    time_t                result_reg, result_next;

    logic [RATE_BITS:0]   trial;
    logic [RATE_BITS:0]   diff;
    logic                 fits;
    rate_t                rem_step;
    time_t                acc_step;
    logic [US_BITS-1:0]   part_step;
    logic [PROD_BITS-1:0] product;

    // One quotient bit per cycle: shift in the next dividend bit and try the rate.
    assign trial     = {rem_reg, dvd_reg[TIME_BITS-1]};
    assign fits      = trial >= {1'b0, rate};
    assign diff      = trial - {1'b0, rate};
    assign rem_step  = fits ? diff[RATE_BITS-1:0] : trial[RATE_BITS-1:0];
    // Whole seconds are scaled on the fly: each quotient bit adds one second.
    assign acc_step  = {acc_reg[TIME_BITS-2:0], 1'b0}
                     + (fits ? TIME_BITS'(US_PER_SECOND) : '0);
    assign part_step = {part_reg[US_BITS-2:0], fits};
    // Remainder scaled to microseconds, the dividend of the second division.
    assign product   = PROD_BITS'(rem_reg) * PROD_BITS'(US_PER_SECOND);

    // Sequencer of the two divisions.
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        dvd_next    = dvd_reg;
        rem_next    = rem_reg;
        acc_next    = acc_reg;
        part_next   = part_reg;
        result_next = result_reg;
        case (state_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    dvd_next   = ticks;
                    rem_next   = '0;
                    acc_next   = '0;
                    cnt_next   = '0;
                    state_next = C_WHOLE;
                end
            end
            C_WHOLE:
            begin
                dvd_next = {dvd_reg[TIME_BITS-2:0], 1'b0};
                rem_next = rem_step;
                acc_next = acc_step;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == WHOLE_LAST)
                begin
                    state_next = C_MUL;
                end
            end
            C_MUL:
            begin
                dvd_next   = {product, (TIME_BITS-PROD_BITS)'(0)};
                rem_next   = '0;
                part_next  = '0;
                cnt_next   = '0;
                state_next = C_PART;
            end
            C_PART:
            begin
                dvd_next  = {dvd_reg[TIME_BITS-2:0], 1'b0};
                rem_next  = rem_step;
                part_next = part_step;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == PART_LAST)
                begin
                    state_next = C_SUM;
                end
            end
            C_SUM:
            begin
                result_next = acc_reg + TIME_BITS'(part_reg);
                done_next   = 1'b1;
                state_next  = C_IDLE;
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        dvd_reg    <= dvd_next;
        rem_reg    <= rem_next;
        acc_reg    <= acc_next;
        part_reg   <= part_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

FILE: design/elapsed_time_microsecond_timer.sv
// Top level of the tick-to-microsecond elapsed timer: item control and timer state.
// An item steps through the states now, tick and finish; a bit-serial conversion (read,
// arm or convert) adds a wait for its result, and a convert that also needs the current
// time for an armed delay waits for two conversions. The next item is taken in the cycle after the
// result is loaded, even while it waits; a still-stalled older result holds the last step.
// Reset (rst_n, asynchronous) sets the rate to 1000000 Hz and clears all timer state.
module elapsed_time_microsecond_timer #(
    parameter int COUNTER_BITS = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  emt_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_stall,
    output emt_pkg::out_item_t out_item,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  emt_pkg::rate_t     cfg_data
);
    import emt_pkg::*;

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_NOW       = 3'd1;
    localparam logic [2:0] S_NOW_WAIT  = 3'd2;
    localparam logic [2:0] S_TICK      = 3'd3;
    localparam logic [2:0] S_TICK_WAIT = 3'd4;
    localparam logic [2:0] S_FINISH    = 3'd5;

    logic [2:0]              state_reg, state_next;
    rate_t                   rate_reg, rate_next;
    logic                    valid_reg, valid_next;
    logic                    armed_reg, armed_next;
    logic [COUNTER_BITS-1:0] origin_reg, origin_next;
    time_t                   deadline_reg, deadline_next;
    in_item_t                item_reg, item_next;
    time_t                   now_reg, now_next;
    time_t                   tconv_reg, tconv_next;
    logic                    out_valid_reg, out_valid_next;
    out_item_t               out_item_reg, out_item_next;

    logic                    accept;
    logic                    out_free;
    logic                    rate_nz;
    logic                    usable;
    logic                    need_now;
    logic                    need_ticks;
    logic [COUNTER_BITS-1:0] elapsed;
    logic                    conv_start;
    time_t                   conv_ticks;
    logic                    conv_done;
    time_t                   conv_result;
    time_t                   now_use;
    time_t                   deadline_sum;
    time_t                   deadline_fin;
    logic                    armed_fin;
    out_item_t               result;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = state_reg != S_IDLE;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;

    // Timer usability and which conversions this item needs.
    assign rate_nz    = rate_reg != '0;
    assign usable     = valid_reg && rate_nz;
    assign need_now   = usable && (item_reg.operation != OP_RESTART)
                     && (item_reg.operation == OP_READ || item_reg.operation == OP_ARM
                         || armed_reg);
    assign need_ticks = rate_nz && (item_reg.operation == OP_CONVERT);

    // Elapsed ticks since the origin, wrapping at the counter width.
    assign elapsed    = item_reg.counter_value[COUNTER_BITS-1:0] - origin_reg;
    assign conv_ticks = (state_reg == S_TICK) ? item_reg.tick_count : TIME_BITS'(elapsed);
    assign conv_start = (state_reg == S_NOW && need_now) || (state_reg == S_TICK && need_ticks);

    emt_conv u_conv (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (conv_start),
        .ticks  (conv_ticks),
        .rate   (rate_reg),
        .done   (conv_done),
        .result (conv_result)
    );

    // Result fields, new deadline and deadline check.
    always_comb
    begin
        now_use           = usable ? now_reg : '0;
        deadline_sum      = now_use + item_reg.delay_us;
        armed_fin         = armed_reg;
        deadline_fin      = deadline_reg;
        result.time_us    = '0;
        result.status     = 1'b1;
        result.delay_done = 1'b1;
        case (item_reg.operation)
            OP_RESTART:
            begin
                result.status = !rate_nz;
            end
            OP_READ:
            begin
                result.time_us = now_use;
                result.status  = !usable;
            end
            OP_CONVERT:
            begin
                result.time_us = rate_nz ? tconv_reg : '0;
                result.status  = !rate_nz;
            end
            OP_ARM:
            begin
                result.time_us = now_use;
                result.status  = !usable;
                if (usable)
                begin
                    if (item_reg.delay_us == '0)
                    begin
                        armed_fin = 1'b0;
                    end
                    else
                    begin
                        deadline_fin = deadline_sum;
                        armed_fin    = 1'b1;
                    end
                end
            end
            default:
            begin
                result.status = 1'b1;
            end
        endcase
        if (armed_fin && usable && now_use >= deadline_fin)
        begin
            armed_fin = 1'b0;
        end
        result.delay_done = !armed_fin;
    end

    // Item sequencer and timer state.
    always_comb
    begin
        state_next     = state_reg;
        rate_next      = rate_reg;
        valid_next     = valid_reg;
        armed_next     = armed_reg;
        origin_next    = origin_reg;
        deadline_next  = deadline_reg;
        item_next      = item_reg;
        now_next       = now_reg;
        tconv_next     = tconv_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_item_next  = out_item_reg;
        if (cfg_valid && cfg_ready)
        begin
            rate_next = cfg_data;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    item_next  = in_item;
                    now_next   = '0;
                    state_next = S_NOW;
                    // Restart takes effect before the current time is formed.
                    if (in_item.operation == OP_RESTART)
                    begin
                        origin_next = in_item.counter_value[COUNTER_BITS-1:0];
                        valid_next  = rate_nz;
                        armed_next  = 1'b0;
                    end
                end
            end
            S_NOW:
            begin
                state_next = need_now ? S_NOW_WAIT : S_TICK;
            end
            S_NOW_WAIT:
            begin
                if (conv_done)
                begin
                    now_next   = conv_result;
                    state_next = S_TICK;
                end
            end
            S_TICK:
            begin
                state_next = need_ticks ? S_TICK_WAIT : S_FINISH;
            end
            S_TICK_WAIT:
            begin
                if (conv_done)
                begin
                    tconv_next = conv_result;
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_item_next  = result;
                    out_valid_next = 1'b1;
                    armed_next     = armed_fin;
                    deadline_next  = deadline_fin;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and timer state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rate_reg      <= RATE_RESET;
            valid_reg     <= 1'b0;
            armed_reg     <= 1'b0;
            origin_reg    <= '0;
            deadline_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rate_reg      <= rate_next;
            valid_reg     <= valid_next;
            armed_reg     <= armed_next;
            origin_reg    <= origin_next;
            deadline_reg  <= deadline_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        now_reg      <= now_next;
        tconv_reg    <= tconv_next;
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

FILE: design/emt_checker.sv
// Port-level checks of the elapsed timer and their attachment to the top level.
module emt_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input emt_pkg::out_item_t out_item
);

    // A stalled result beat keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("stalled result beat changed");

    // An accepted item keeps the block busy in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken again right after an accept");

    // A new result appears only at the end of an item's work.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without an item in work");

    // An invalid result carries zero time.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.status |-> out_item.time_us == '0)
        else $error("invalid result with nonzero time");

endmodule

bind elapsed_time_microsecond_timer emt_checker u_emt_checker (.*);
